### src/slcd_pkg.sv
// Shared constants and types for the sync/length/checksum deframer.
// No dependencies; imported by every other file of the block.
package slcd_pkg;

  localparam int LANES    = 4;
  localparam int BANK_AW  = 6;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = LANES * BYTE_W;
  localparam int CFG_IW   = 2;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_THIRD_RST  = 8'hF1;

  localparam logic [CFG_IW-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SYNC_THIRD  = 2'd2;

  localparam logic [1:0] ST_WORD  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  typedef struct packed {
    logic load_len;
    logic pay_wr;
    logic sum_wr;
    logic wcnt_clr;
    logic rd_en;
    logic rd_step;
    logic word_sel;
  } slcd_cmd_t;

  typedef struct packed {
    logic match1;
    logic match2;
    logic match3;
    logic sync12_eq;
    logic byte_zero;
    logic pay_done;
    logic sum_ok;
    logic words_zero;
    logic last_word;
  } slcd_flags_t;

endpackage

### src/slcd_ram.sv
// One byte lane of the packet store: 64 x 8, one write and one registered read.
// Depends on slcd_pkg.
module slcd_ram import slcd_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [BANK_AW-1:0] waddr,
  input  logic [BYTE_W-1:0]  wdata,
  input  logic               re,
  input  logic [BANK_AW-1:0] raddr,
  output logic [BYTE_W-1:0]  rdata
);

  logic [BYTE_W-1:0] mem [1 << BANK_AW];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/slcd_dpath.sv
// Datapath: sync registers, length, counters, running sum, lane store, word out.
// Depends on slcd_pkg and slcd_ram.
module slcd_dpath import slcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  slcd_cmd_t         cmd,
  output slcd_flags_t       flags,
  output logic [WORD_W-1:0] out_payload_word
);

  logic [BYTE_W-1:0] sync1_r, sync2_r, sync3_r;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BANK_AW-1:0] wcnt_r, wcnt_nxt;
  logic [BYTE_W:0]   cnt_inc;
  logic [BYTE_W:0]   len_plus;
  logic [BANK_AW:0]  words;
  logic [BYTE_W-1:0] wr_addr;
  logic [BANK_AW-1:0] rd_addr;
  logic [BYTE_W-1:0] lane_data [LANES];
  logic [WORD_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync1_r <= SYNC_FIRST_RST;
      sync2_r <= SYNC_SECOND_RST;
      sync3_r <= SYNC_THIRD_RST;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      wcnt_r  <= '0;
    end else begin
      if (cfg_wr_en && cfg_index == CFG_SYNC_FIRST)  sync1_r <= cfg_wdata;
      if (cfg_wr_en && cfg_index == CFG_SYNC_SECOND) sync2_r <= cfg_wdata;
      if (cfg_wr_en && cfg_index == CFG_SYNC_THIRD)  sync3_r <= cfg_wdata;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      wcnt_r <= wcnt_nxt;
    end
  end

  always_comb begin
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    wcnt_nxt = wcnt_r;
    if (cmd.load_len) begin
      len_nxt = in_rx_byte;
      cnt_nxt = '0;
      sum_nxt = sync1_r + sync2_r + sync3_r + in_rx_byte;
    end
    if (cmd.pay_wr) begin
      cnt_nxt = cnt_inc[BYTE_W-1:0];
      sum_nxt = sum_r + in_rx_byte;
    end
    if (cmd.wcnt_clr) wcnt_nxt = '0;
    if (cmd.rd_step)  wcnt_nxt = wcnt_r + 1'b1;
  end

  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;
  assign len_plus = {1'b0, len_r} + (BYTE_W+1)'(5);
  assign words    = len_plus[BYTE_W:2] - 1'b1;

  assign flags.match1     = (in_rx_byte == sync1_r);
  assign flags.match2     = (in_rx_byte == sync2_r);
  assign flags.match3     = (in_rx_byte == sync3_r);
  assign flags.sync12_eq  = (sync1_r == sync2_r);
  assign flags.byte_zero  = (in_rx_byte == '0);
  assign flags.pay_done   = (cnt_inc >= {1'b0, len_r});
  assign flags.sum_ok     = (in_rx_byte == sum_r);
  assign flags.words_zero = (words == '0);
  assign flags.last_word  = (({1'b0, wcnt_r} + 1'b1) == words);

  assign wr_addr = cmd.sum_wr ? len_r : cnt_r;
  assign rd_addr = cmd.rd_step ? (wcnt_r + 1'b1) : wcnt_r;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    slcd_ram u_ram (
      .clk   (clk),
      .we    ((cmd.pay_wr || cmd.sum_wr) && wr_addr[1:0] == 2'(i)),
      .waddr (wr_addr[BYTE_W-1:2]),
      .wdata (in_rx_byte),
      .re    (cmd.rd_en),
      .raddr (rd_addr),
      .rdata (lane_data[i])
    );
    // lane 0 holds the lowest packet offset, so it is the top byte
    assign rd_word[WORD_W-1-BYTE_W*i -: BYTE_W] = lane_data[i];
  end

  assign out_payload_word = cmd.word_sel ? rd_word : '0;

endmodule

### src/slcd_ctrl.sv
// Controller: sync hunt, length/payload/checksum sequencing and result drain.
// Depends on slcd_pkg; drives the datapath through slcd_cmd_t.
module slcd_ctrl import slcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  slcd_flags_t flags,
  output slcd_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_HUNT, S_ONE, S_TWO, S_LEN, S_PAY, S_SUM, S_RD, S_SHOW, S_STAT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic       in_acc, out_acc;

  assign in_stall  = !(state_r == S_HUNT || state_r == S_ONE || state_r == S_TWO ||
                       state_r == S_LEN  || state_r == S_PAY || state_r == S_SUM);
  assign out_valid = (state_r == S_SHOW) || (state_r == S_STAT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign out_status = (state_r == S_SHOW) ? ST_WORD : stat_r;
  assign out_last   = (state_r == S_SHOW) ? flags.last_word : 1'b1;

  always_comb begin
    state_nxt = state_r;
    stat_nxt  = stat_r;
    cmd       = '0;
    cmd.word_sel = (state_r == S_SHOW);
    case (state_r)
      S_HUNT: begin
        if (in_acc) state_nxt = flags.match1 ? S_ONE : S_HUNT;
      end
      S_ONE: begin
        if (in_acc) begin
          if (flags.match2)      state_nxt = S_TWO;
          else if (flags.match1) state_nxt = S_ONE;
          else                   state_nxt = S_HUNT;
        end
      end
      S_TWO: begin
        if (in_acc) begin
          if (flags.match3)                         state_nxt = S_LEN;
          else if (flags.sync12_eq && flags.match2) state_nxt = S_TWO;
          else if (flags.match1)                    state_nxt = S_ONE;
          else                                      state_nxt = S_HUNT;
        end
      end
      S_LEN: begin
        if (in_acc) begin
          cmd.load_len = 1'b1;
          state_nxt = flags.byte_zero ? S_SUM : S_PAY;
        end
      end
      S_PAY: begin
        if (in_acc) begin
          cmd.pay_wr = 1'b1;
          if (flags.pay_done) state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (in_acc) begin
          cmd.wcnt_clr = 1'b1;
          if (!flags.sum_ok) begin
            stat_nxt  = ST_ERR;
            state_nxt = S_STAT;
          end else begin
            cmd.sum_wr = 1'b1;
            if (flags.words_zero) begin
              stat_nxt  = ST_EMPTY;
              state_nxt = S_STAT;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SHOW;
      end
      S_SHOW: begin
        if (out_acc) begin
          if (flags.last_word) begin
            state_nxt = S_HUNT;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_step = 1'b1;
          end
        end
      end
      S_STAT: begin
        if (out_acc) state_nxt = S_HUNT;
      end
      default: begin
        state_nxt = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
      stat_r  <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
    end
  end

endmodule

### src/sync_length_checksum_deframer.sv
// Top level of the deframer: controller plus datapath.
// Depends on slcd_pkg, slcd_ctrl and slcd_dpath.
//
// Bytes are taken one per cycle while the block hunts for the three sync
// bytes and receives the length, payload and checksum bytes, so a packet of
// length L occupies L+5 input beats counting its first sync byte. Once the
// checksum byte is taken the input stalls while results drain: a checksum
// error or a packet too short for any word gives one status beat in the
// following cycle; otherwise W = floor((L+5)/4)-1 words follow a registered
// RAM read, one word per cycle while the receiver does not stall, from four
// byte-lane RAMs read in parallel. Hunting resumes the cycle after the
// final result is taken. No clearing pass is needed after reset.
module sync_length_checksum_deframer import slcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_payload_word,
  output logic [1:0]        out_status,
  output logic              out_last
);

  slcd_cmd_t   cmd;
  slcd_flags_t flags;

  slcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_last   (out_last),
    .flags      (flags),
    .cmd        (cmd)
  );

  slcd_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .flags            (flags),
    .out_payload_word (out_payload_word)
  );

  a_no_rx_while_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  a_status_beat_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_WORD) |-> (out_payload_word == '0 && out_last))
    else $error("status beat with payload or without last");

  a_resume_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> (!in_stall && !out_valid))
    else $error("hunt not resumed after final beat");

endmodule

### bench/tb.sv
// Self-checking bench for sync_length_checksum_deframer: directed frames, sync settings and
// random traffic, with results checked against a behavioural frame parser kept in the bench.
// Depends on slcd_pkg and the deframer RTL only.
module tb;
  import slcd_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [1:0]        status;
    logic              last;
  } frame_result_t;

  typedef enum logic [2:0] {
    HUNT, GOT_ONE, GOT_TWO, WANT_LEN, IN_PAYLOAD, WANT_SUM
  } hunt_t;

  localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;

  localparam int RX_FREE    = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [BYTE_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_payload_word;
  logic [1:0]        out_status;
  logic              out_last;

  sync_length_checksum_deframer u_dut (.*);

  always #5 clk = ~clk;

  // parser state
  logic [BYTE_W-1:0] sync_reg [3] = '{SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_THIRD_RST};
  hunt_t             phase = HUNT;
  logic [7:0]        frame_len = '0;
  logic [8:0]        pay_count = '0;
  logic [7:0]        run_sum = '0;
  logic [7:0]        frame_store [256];
  frame_result_t     frame_results_q [$];

  int  n_bytes = 0, n_checked = 0, n_errors = 0;
  int  n_words = 0, n_empty = 0, n_bad_sum = 0;
  bit  gaps_on = 1'b0;
  int  burst_left = 0;
  int  rx_mode = RX_FREE;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  rx_cycle = 0;

  function automatic void deframe_byte(input logic [7:0] b);
    int nwords;
    int base;
    case (phase)
      GOT_ONE: begin
        if (b == sync_reg[1]) phase = GOT_TWO;
        else phase = (b == sync_reg[0]) ? GOT_ONE : HUNT;
      end
      GOT_TWO: begin
        if (b == sync_reg[2]) phase = WANT_LEN;
        else if (sync_reg[1] == sync_reg[0] && b == sync_reg[1]) phase = GOT_TWO;
        else phase = (b == sync_reg[0]) ? GOT_ONE : HUNT;
      end
      WANT_LEN: begin
        frame_len = b;
        pay_count = '0;
        run_sum = sync_reg[0] + sync_reg[1] + sync_reg[2] + b;
        phase = (b == 8'd0) ? WANT_SUM : IN_PAYLOAD;
      end
      IN_PAYLOAD: begin
        frame_store[pay_count[7:0]] = b;
        run_sum = run_sum + b;
        pay_count = pay_count + 9'd1;
        if (pay_count >= {1'b0, frame_len}) phase = WANT_SUM;
      end
      WANT_SUM: begin
        phase = HUNT;
        if (b != run_sum) begin
          frame_results_q.push_back('{word: '0, status: ST_ERR, last: 1'b1});
        end else begin
          frame_store[frame_len] = b;
          nwords = (int'(frame_len) + 5) / 4 - 1;
          if (nwords == 0) begin
            frame_results_q.push_back('{word: '0, status: ST_EMPTY, last: 1'b1});
          end else begin
            for (int k = 0; k < nwords; k++) begin
              base = 4 * k;
              frame_results_q.push_back('{
                word: {frame_store[base], frame_store[base + 1],
                       frame_store[base + 2], frame_store[base + 3]},
                status: ST_WORD, last: (k + 1 == nwords)});
            end
          end
        end
      end
      default: phase = (b == sync_reg[0]) ? GOT_ONE : HUNT;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    deframe_byte(b);
    n_bytes++;
  endtask

  task automatic send_seq(input logic [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic send_frame(input logic [7:0] len, input bit bad_sum);
    logic [7:0] seq [$];
    logic [7:0] b;
    logic [7:0] sum;
    int i;
    seq = {sync_reg[0], sync_reg[1], sync_reg[2], len};
    sum = sync_reg[0] + sync_reg[1] + sync_reg[2] + len;
    for (i = 0; i < len; i++) begin
      b = 8'($urandom);
      seq.push_back(b);
      sum = sum + b;
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    seq.push_back(sum);
    send_seq(seq);
  endtask

  function automatic logic [7:0] non_sync_byte();
    logic [7:0] b;
    b = 8'h01;
    while (b == sync_reg[0] || b == sync_reg[1] || b == sync_reg[2]) b = b + 8'd1;
    return b;
  endfunction

  // bring the parser back to hunting, then wait for all results to drain
  task automatic settle();
    while (phase != HUNT) begin
      case (phase)
        WANT_LEN:   send_byte(8'h00);
        IN_PAYLOAD: send_byte(8'($urandom));
        WANT_SUM:   send_byte(run_sum);
        default:    send_byte(non_sync_byte());
      endcase
    end
    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_sync(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    logic [7:0] vals [4];
    logic [CFG_IW-1:0] idx [4];
    settle();
    vals = '{a, b, c, 8'($urandom)};
    idx  = '{CFG_SYNC_FIRST, CFG_SYNC_SECOND, CFG_SYNC_THIRD, CFG_UNUSED};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      if (idx[i] != CFG_UNUSED) sync_reg[idx[i]] = vals[i];
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] short_len();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 12));
    return 8'($urandom_range(13, 40));
  endfunction

  // receiver: stall patterns plus one long hold on request
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 500;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_RANDOM:  out_stall <= ($urandom_range(0, 99) < 40);
        RX_PATTERN: out_stall <= (rx_cycle % 7 < 3) || (rx_cycle % 53 > 44);
        default:    out_stall <= 1'b0;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_checked++;
      if (frame_results_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected beat word=%h status=%0d last=%0b",
                 $time, out_payload_word, out_status, out_last);
      end else begin
        want = frame_results_q.pop_front();
        case (want.status)
          ST_WORD:  n_words++;
          ST_EMPTY: n_empty++;
          default:  n_bad_sum++;
        endcase
        if (out_payload_word !== want.word) begin
          n_errors++;
          $display("%0t: payload_word expected %h got %h", $time, want.word, out_payload_word);
        end
        if (out_status !== want.status) begin
          n_errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
        end
        if (out_last !== want.last) begin
          n_errors++;
          $display("%0t: last expected %0b got %0b", $time, want.last, out_last);
        end
      end
    end
  end

  task automatic test_reset_sync_frames();
    gaps_on = 1'b0;
    rx_mode = RX_FREE;
    // noise, empty frame, overlapping sync with a one-word frame, bad checksum
    send_seq({8'h00, 8'hFF});
    send_seq({8'hAA, 8'hAA, 8'hF1, 8'h00, 8'h45});
    send_seq({8'hAA, 8'hAA, 8'hAA, 8'hF1, 8'h03, 8'h00, 8'hFF, 8'h80, 8'hC7});
    send_seq({8'hAA, 8'hAA, 8'hF1, 8'h02, 8'h12, 8'h34, 8'h8C});
    settle();
  endtask

  task automatic test_sync_extremes();
    logic [7:0] a [4];
    logic [7:0] b [4];
    logic [7:0] c [4];
    a = '{8'h00, 8'hFF, 8'hFF, 8'h5A};
    b = '{8'h00, 8'hFF, 8'h00, 8'hA5};
    c = '{8'h00, 8'hFF, 8'hFF, 8'h5A};
    rx_mode = RX_RANDOM;
    for (int s = 0; s < 4; s++) begin
      set_sync(a[s], b[s], c[s]);
      send_frame(8'd0, 1'b0);
      send_byte(a[s]);
      send_byte(non_sync_byte());
      send_frame(8'd3, 1'b0);
      send_frame(8'd6, 1'b1);
      send_frame(8'd2, 1'b0);
    end
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    gaps_on = 1'b1;
    for (int half = 0; half < 2; half++) begin
      if (half == 0) begin
        set_sync(8'($urandom), 8'($urandom), 8'($urandom));
        rx_mode = RX_RANDOM;
      end else begin
        set_sync(SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_THIRD_RST);
        rx_mode = RX_PATTERN;
      end
      start = n_bytes;
      while (n_bytes - start < 45) begin
        pick = $urandom_range(0, 99);
        if (pick < 62) send_frame(short_len(), 1'b0);
        else if (pick < 72) send_frame(short_len(), 1'b1);
        else if (pick < 84) repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
        else begin
          // header cut short
          send_byte(sync_reg[0]);
          if ($urandom_range(0, 1)) send_byte(sync_reg[1]);
          send_byte(8'($urandom));
        end
      end
    end
    settle();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    rx_mode = RX_FREE;
    hold_req = 1'b1;
    send_frame(8'd120, 1'b0);
    send_frame(8'd8, 1'b0);
    send_frame(8'd1, 1'b1);
    send_frame(8'd11, 1'b0);
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_sync_frames();
    test_sync_extremes();
    test_random_traffic();
    test_backpressure();
    settle();
    $display("tb: %0d bytes sent over 7 sync settings with bursts, stalls and a long hold",
             n_bytes);
    $display("tb: %0d beats checked: %0d words, %0d empty frames, %0d checksum errors",
             n_checked, n_words, n_empty, n_bad_sum);
    if (n_errors == 0 && frame_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
